FILE: hw/rtl/meminfo_text_parser_defines.svh
// Assertion macros shared by the memory-information parser.
`ifndef MEMINFO_TEXT_PARSER_DEFINES_SVH
`define MEMINFO_TEXT_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEMINFO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("meminfo assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MEMINFO_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("meminfo assertion failed");

`endif

FILE: hw/rtl/meminfo_pkg.sv
`timescale 1ns / 1ps

package meminfo_pkg;

   localparam int MAX_TEXT_LENGTH = 65536;
   localparam int VALUE_WIDTH = 54;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_PARSE   = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_B = 8'h42;
   localparam logic [7:0] CHAR_LOWER_K = 8'h6B;

   localparam logic [3:0] TOTAL_KEY_LENGTH = 4'd8;
   localparam logic [3:0] AVAIL_KEY_LENGTH = 4'd12;
   localparam logic [3:0] KEY_COUNT_LIMIT  = 4'd13;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_SKIP,
      PH_PRE,
      PH_DIGITS,
      PH_GAP,
      PH_K,
      PH_POST
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] total_bytes;
      logic [63:0] available_bytes;
   } rsp_type;

   function automatic logic [7:0] total_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = "M";
         3'd1: c = "e";
         3'd2: c = "m";
         3'd3: c = "T";
         3'd4: c = "o";
         3'd5: c = "t";
         3'd6: c = "a";
         3'd7: c = "l";
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] avail_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:  c = "M";
         4'd1:  c = "e";
         4'd2:  c = "m";
         4'd3:  c = "A";
         4'd4:  c = "v";
         4'd5:  c = "a";
         4'd6:  c = "i";
         4'd7:  c = "l";
         4'd8:  c = "a";
         4'd9:  c = "b";
         4'd10: c = "l";
         4'd11: c = "e";
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
   endfunction

endpackage

FILE: hw/rtl/meminfo_scan.sv
`timescale 1ns / 1ps

module meminfo_scan #(
   parameter int MAX_TEXT_LENGTH = meminfo_pkg::MAX_TEXT_LENGTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  meminfo_pkg::req_type step_data,
   output meminfo_pkg::rsp_type step_result
);

   localparam int CountWidth = $clog2(MAX_TEXT_LENGTH + 2);
   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_TEXT_LENGTH);
   localparam int VW = meminfo_pkg::VALUE_WIDTH;

   meminfo_pkg::phase_type phase_ff, phase_in;
   logic [3:0]            key_count_ff, key_count_in;
   logic [1:0]            key_match_ff, key_match_in;
   logic                  current_key_ff, current_key_in;
   logic [1:0]            found_keys_ff, found_keys_in;
   logic [VW-1:0]         digit_value_ff, digit_value_in;
   logic [VW-1:0]         total_store_ff, total_store_in;
   logic [VW-1:0]         available_store_ff, available_store_in;
   logic                  parse_failed_ff, parse_failed_in;
   logic                  argument_bad_ff, argument_bad_in;
   logic [CountWidth-1:0] byte_count_ff, byte_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= meminfo_pkg::PH_KEY;
         key_count_ff       <= '0;
         key_match_ff       <= 2'b11;
         current_key_ff     <= 1'b0;
         found_keys_ff      <= '0;
         digit_value_ff     <= '0;
         total_store_ff     <= '0;
         available_store_ff <= '0;
         parse_failed_ff    <= 1'b0;
         argument_bad_ff    <= 1'b0;
         byte_count_ff      <= '0;
      end else begin
         phase_ff           <= phase_in;
         key_count_ff       <= key_count_in;
         key_match_ff       <= key_match_in;
         current_key_ff     <= current_key_in;
         found_keys_ff      <= found_keys_in;
         digit_value_ff     <= digit_value_in;
         total_store_ff     <= total_store_in;
         available_store_ff <= available_store_in;
         parse_failed_ff    <= parse_failed_in;
         argument_bad_ff    <= argument_bad_in;
         byte_count_ff      <= byte_count_in;
      end
   end

   always_comb begin
      logic [7:0]    b;
      logic          digit;
      logic [1:0]    key_bit;
      logic [VW+3:0] scaled;
      logic [1:0]    status;

      b       = step_data.text_byte;
      digit   = (b >= meminfo_pkg::CHAR_ZERO) && (b <= meminfo_pkg::CHAR_NINE);
      key_bit = 2'b00;
      scaled  = ({4'b0, digit_value_ff} << 3) + ({4'b0, digit_value_ff} << 1)
                + (VW + 4)'(b[3:0]);
      status  = meminfo_pkg::STATUS_OK;

      phase_in           = phase_ff;
      key_count_in       = key_count_ff;
      key_match_in       = key_match_ff;
      current_key_in     = current_key_ff;
      found_keys_in      = found_keys_ff;
      digit_value_in     = digit_value_ff;
      total_store_in     = total_store_ff;
      available_store_in = available_store_ff;
      parse_failed_in    = parse_failed_ff;
      argument_bad_in    = argument_bad_ff;
      byte_count_in      = byte_count_ff;
      step_result        = '0;

      if (step_valid) begin
         if (byte_count_ff <= MaxCount) begin
            byte_count_in = byte_count_ff + CountWidth'(1);
         end
         if ((byte_count_in > MaxCount) || (b == meminfo_pkg::CHAR_NUL)) begin
            argument_bad_in = 1'b1;
         end

         if (b != meminfo_pkg::CHAR_LF) begin
            case (phase_ff)
               meminfo_pkg::PH_KEY: begin
                  if (b == meminfo_pkg::CHAR_COLON) begin
                     if (key_match_ff[0] && (key_count_ff == meminfo_pkg::TOTAL_KEY_LENGTH)) begin
                        key_bit = 2'b01;
                     end
                     if (key_match_ff[1] && (key_count_ff == meminfo_pkg::AVAIL_KEY_LENGTH)) begin
                        key_bit = 2'b10;
                     end
                     if (key_bit == 2'b00) begin
                        phase_in = meminfo_pkg::PH_SKIP;
                     end else if ((found_keys_ff & key_bit) != 2'b00) begin
                        parse_failed_in = 1'b1;
                        phase_in        = meminfo_pkg::PH_SKIP;
                     end else begin
                        current_key_in = key_bit[1];
                        phase_in       = meminfo_pkg::PH_PRE;
                     end
                  end else begin
                     if ((key_count_ff >= meminfo_pkg::TOTAL_KEY_LENGTH) ||
                         (meminfo_pkg::total_char(key_count_ff[2:0]) != b)) begin
                        key_match_in[0] = 1'b0;
                     end
                     if ((key_count_ff >= meminfo_pkg::AVAIL_KEY_LENGTH) ||
                         (meminfo_pkg::avail_char(key_count_ff) != b)) begin
                        key_match_in[1] = 1'b0;
                     end
                     if (key_count_ff < meminfo_pkg::KEY_COUNT_LIMIT) begin
                        key_count_in = key_count_ff + 4'd1;
                     end
                  end
               end
               meminfo_pkg::PH_PRE: begin
                  if (digit) begin
                     digit_value_in = VW'(b[3:0]);
                     phase_in       = meminfo_pkg::PH_DIGITS;
                  end else if (!meminfo_pkg::is_blank(b)) begin
                     parse_failed_in = 1'b1;
                     phase_in        = meminfo_pkg::PH_SKIP;
                  end
               end
               meminfo_pkg::PH_DIGITS: begin
                  if (digit) begin
                     if (scaled[VW+3:VW] != 4'd0) begin
                        parse_failed_in = 1'b1;
                        phase_in        = meminfo_pkg::PH_SKIP;
                     end else begin
                        digit_value_in = scaled[VW-1:0];
                     end
                  end else if (meminfo_pkg::is_blank(b)) begin
                     phase_in = meminfo_pkg::PH_GAP;
                  end else begin
                     parse_failed_in = 1'b1;
                     phase_in        = meminfo_pkg::PH_SKIP;
                  end
               end
               meminfo_pkg::PH_GAP: begin
                  if (b == meminfo_pkg::CHAR_LOWER_K) begin
                     phase_in = meminfo_pkg::PH_K;
                  end else if (!meminfo_pkg::is_blank(b)) begin
                     parse_failed_in = 1'b1;
                     phase_in        = meminfo_pkg::PH_SKIP;
                  end
               end
               meminfo_pkg::PH_K: begin
                  if (b == meminfo_pkg::CHAR_UPPER_B) begin
                     phase_in = meminfo_pkg::PH_POST;
                  end else begin
                     parse_failed_in = 1'b1;
                     phase_in        = meminfo_pkg::PH_SKIP;
                  end
               end
               meminfo_pkg::PH_POST: begin
                  if (!meminfo_pkg::is_blank(b)) begin
                     parse_failed_in = 1'b1;
                     phase_in        = meminfo_pkg::PH_SKIP;
                  end
               end
               default: begin
               end
            endcase
         end

         // A newline or the final byte closes the current line.
         if ((b == meminfo_pkg::CHAR_LF) || step_data.last_byte) begin
            if (phase_in == meminfo_pkg::PH_POST) begin
               if (current_key_in) begin
                  available_store_in = digit_value_in;
                  found_keys_in      = found_keys_in | 2'b10;
               end else begin
                  total_store_in = digit_value_in;
                  found_keys_in  = found_keys_in | 2'b01;
               end
            end else if (phase_in != meminfo_pkg::PH_SKIP) begin
               parse_failed_in = 1'b1;
            end
            phase_in       = meminfo_pkg::PH_KEY;
            key_count_in   = '0;
            key_match_in   = 2'b11;
            current_key_in = 1'b0;
            digit_value_in = '0;
         end

         if (step_data.last_byte) begin
            if (argument_bad_in) begin
               status = meminfo_pkg::STATUS_INVALID;
            end else if (parse_failed_in || (found_keys_in != 2'b11) ||
                         (total_store_in == '0) ||
                         (available_store_in > total_store_in)) begin
               status = meminfo_pkg::STATUS_PARSE;
            end
            step_result.status = status;
            if (status == meminfo_pkg::STATUS_OK) begin
               step_result.total_bytes     = {total_store_in, 10'd0};
               step_result.available_bytes = {available_store_in, 10'd0};
            end
            found_keys_in      = '0;
            total_store_in     = '0;
            available_store_in = '0;
            parse_failed_in    = 1'b0;
            argument_bad_in    = 1'b0;
            byte_count_in      = '0;
         end
      end
   end

endmodule

FILE: hw/rtl/meminfo_text_parser.sv
`timescale 1ns / 1ps
// The result of a text is registered in rsp_ff once its last byte leaves the input register stage_ff.
// Throughput: one byte per cycle, set by the line scanner's state update; a stalled result can pause it.
// A stalled result holds only the final byte back; earlier bytes keep flowing.
// Reset is synchronous and active high and returns the parser to the start of a new text.
// After each result all parse state returns to its reset values.

`include "meminfo_text_parser_defines.svh"

module meminfo_text_parser #(
   parameter int MAX_TEXT_LENGTH = meminfo_pkg::MAX_TEXT_LENGTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  meminfo_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output meminfo_pkg::rsp_type rsp_data
);

   logic                 stage_valid_ff, stage_valid_in;
   meminfo_pkg::req_type stage_ff, stage_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   meminfo_pkg::rsp_type rsp_ff, rsp_in;
   meminfo_pkg::rsp_type scan_result;
   logic                 advance;
   logic                 accept;

   // A final byte may leave the input register only when the result register is empty or its result is taken.
   assign advance   = stage_valid_ff && (!stage_ff.last_byte || !rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   meminfo_scan #(
      .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_data  (stage_ff),
      .step_result(scan_result)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      if (advance) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_in       = req_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && stage_ff.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_in       = scan_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MEMINFO_ASSERT_IMP(a_stall_needs_item, clock, reset, req_stall, stage_valid_ff && stage_ff.last_byte)
   `MEMINFO_ASSERT_IMP(a_error_clears_sizes, clock, reset, rsp_valid_ff && (rsp_ff.status != meminfo_pkg::STATUS_OK), (rsp_ff.total_bytes == 64'd0) && (rsp_ff.available_bytes == 64'd0))
   `MEMINFO_ASSERT_IMP(a_ok_sizes_sane, clock, reset, rsp_valid_ff && (rsp_ff.status == meminfo_pkg::STATUS_OK), (rsp_ff.total_bytes != 64'd0) && (rsp_ff.available_bytes <= rsp_ff.total_bytes) && (rsp_ff.total_bytes[9:0] == 10'd0))
   `MEMINFO_ASSERT_NEXT(a_last_byte_yields_result, clock, reset, advance && stage_ff.last_byte, rsp_valid_ff)

endmodule
